FILE: rtl/mesh_vertex_normal_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on clk; the reset-gated form is off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define MVNA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MVNA_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MVNA_ASSERT(lbl, prop, msg)
`define MVNA_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: rtl/mvna_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_pkg
// Constants and types shared by the vertex normal accumulator.
// ----------------------------------------------------------------------------
package mvna_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int VCOUNT_W     = 11;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_TRI   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOFACE = 3'd1;
	localparam logic [2:0] ST_RANGE  = 3'd2;
	localparam logic [2:0] ST_REJECT = 3'd3;
	localparam logic [2:0] ST_DEGEN  = 3'd4;

	localparam logic REG_VERTEX_COUNT    = 1'b0;
	localparam logic REG_NORMALS_PRESENT = 1'b1;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} pos_t;

	typedef struct packed {
		logic [15:0]      faces;
		logic [2:0][31:0] sum;
	} acc_entry_t;

endpackage

FILE: rtl/mesh_vertex_normal_accumulator.sv
`timescale 1ns / 1ps
// Load, rejected and out-of-range items: result strobe the cycle after the transfer.
// Read: a vertex with no faces ends after the face check, a zero sum after the zero check, else
// after the group shift, the root and three divides. Triangle: a degenerate one ends after the
// cross product, else the cross product, the shift, the root, three divides and three updates run.
// Clear: strobe the cycle after, then a sweep of every accumulator RAM entry, busy high.
// arst_n clears control state and starts that sweep; results cannot be stalled.
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator
// Vertex position store with per-vertex face normal sums and face counts.
// ----------------------------------------------------------------------------
`include "mesh_vertex_normal_accumulator_macros.svh"

module mesh_vertex_normal_accumulator
	import mvna_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	output logic                      done,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [VCOUNT_W-1:0]       cfg_data,
	input  logic [1:0]                operation,
	input  logic [9:0]                vertex_index,
	input  logic signed [31:0]        coord_x,
	input  logic signed [31:0]        coord_y,
	input  logic signed [31:0]        coord_z,
	input  logic [9:0]                corner_a,
	input  logic [9:0]                corner_b,
	input  logic [9:0]                corner_c,
	output logic [2:0]                status,
	output logic signed [15:0]        normal_x,
	output logic signed [15:0]        normal_y,
	output logic signed [15:0]        normal_z,
	output logic [15:0]               face_count
);

	typedef enum logic [4:0] {
		S_SWEEP, S_IDLE, S_RD_CHK, S_POS_B, S_POS_C, S_EDGE, S_SCALE, S_CROSS,
		S_CHECK, S_NORM, S_SQ, S_SQRT, S_DIV_INIT, S_DIV, S_FIN, S_ACC_RD,
		S_DOT, S_ACC_WR
	} state_t;

	state_t state_q;

	logic [VCOUNT_W-1:0] vertex_count_q;
	logic                normals_present_q;

	pos_t       pos_mem [MAX_VERTICES];
	acc_entry_t acc_mem [MAX_VERTICES];

	logic [ADDR_W-1:0] sweep_addr_q;
	logic              mode_tri_q;
	logic [ADDR_W-1:0] cor_q [3];
	logic [1:0]        corner_k_q;
	pos_t              pos_rd_q;
	pos_t              pa_q;
	logic signed [32:0] e1_q [3];
	logic signed [32:0] e2_q [3];
	logic [4:0]        cnt_q;
	logic signed [63:0] tmp_q;
	logic signed [63:0] vec_q [3];
	logic              neg_q [3];
	logic [63:0]       mag_q [3];
	logic [49:0]       sq_q;
	logic [27:0]       rem_q;
	logic [24:0]       root_q;
	logic [39:0]       num_q;
	logic [40:0]       dsh_q;
	logic [15:0]       quo_q;
	logic [1:0]        comp_q;
	logic signed [15:0] nrm_q [3];
	logic signed [49:0] dot_q;
	acc_entry_t        acc_rd_q;
	logic [15:0]       fc_q;

	logic              done_q;
	logic [2:0]        status_q;
	logic signed [15:0] nx_q, ny_q, nz_q;
	logic [15:0]       fc_out_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p_s1;

	logic [VCOUNT_W-1:0] lim;
	logic                accept;
	logic [63:0]         max_mag;
	logic                wide;
	logic [ADDR_W-1:0]   pos_raddr;
	logic [ADDR_W-1:0]   acc_raddr;
	logic                acc_re;
	logic                acc_we;
	logic [ADDR_W-1:0]   acc_waddr;
	acc_entry_t          acc_wdata;
	logic [27:0]         sqrt_rem;
	logic [27:0]         sqrt_trial;
	logic                div_bit;
	logic [15:0]         quo_next;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign lim    = (vertex_count_q > VCOUNT_W'(MAX_VERTICES)) ?
	                VCOUNT_W'(MAX_VERTICES) : vertex_count_q;

	assign done       = done_q;
	assign status     = status_q;
	assign normal_x   = nx_q;
	assign normal_y   = ny_q;
	assign normal_z   = nz_q;
	assign face_count = fc_out_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q    <= '0;
			normals_present_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VERTEX_COUNT:    vertex_count_q    <= cfg_data;
				REG_NORMALS_PRESENT: normals_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		max_mag = mag_q[0];
		if (mag_q[1] > max_mag) max_mag = mag_q[1];
		if (mag_q[2] > max_mag) max_mag = mag_q[2];
	end

	always_comb begin
		wide = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (e1_q[i] >= 33'sd1073741824 || e1_q[i] <= -33'sd1073741824 ||
			    e2_q[i] >= 33'sd1073741824 || e2_q[i] <= -33'sd1073741824)
				wide = 1'b1;
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CROSS: begin
				case (cnt_q)
					5'd0: begin mul_a = e1_q[1][31:0]; mul_b = e2_q[2][31:0]; end
					5'd1: begin mul_a = e1_q[2][31:0]; mul_b = e2_q[1][31:0]; end
					5'd2: begin mul_a = e1_q[2][31:0]; mul_b = e2_q[0][31:0]; end
					5'd3: begin mul_a = e1_q[0][31:0]; mul_b = e2_q[2][31:0]; end
					5'd4: begin mul_a = e1_q[0][31:0]; mul_b = e2_q[1][31:0]; end
					5'd5: begin mul_a = e1_q[1][31:0]; mul_b = e2_q[0][31:0]; end
					default: ;
				endcase
			end
			S_SQ: begin
				case (cnt_q)
					5'd0: begin mul_a = mag_q[0][31:0]; mul_b = mag_q[0][31:0]; end
					5'd1: begin mul_a = mag_q[1][31:0]; mul_b = mag_q[1][31:0]; end
					5'd2: begin mul_a = mag_q[2][31:0]; mul_b = mag_q[2][31:0]; end
					default: ;
				endcase
			end
			S_DOT: begin
				case (cnt_q)
					5'd0: begin mul_a = 32'(nrm_q[0]); mul_b = $signed(acc_rd_q.sum[0]); end
					5'd1: begin mul_a = 32'(nrm_q[1]); mul_b = $signed(acc_rd_q.sum[1]); end
					5'd2: begin mul_a = 32'(nrm_q[2]); mul_b = $signed(acc_rd_q.sum[2]); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_p_s1 <= mul_a * mul_b;
	end

	// square root step: two radicand bits in, one root bit out
	assign sqrt_rem   = {rem_q[25:0], sq_q[49:48]};
	assign sqrt_trial = {1'b0, root_q, 2'b01};

	assign div_bit  = ({1'b0, num_q} >= dsh_q);
	assign quo_next = {quo_q[14:0], div_bit};

	// memory ports
	always_comb begin
		pos_raddr = corner_a;
		case (state_q)
			S_POS_B: pos_raddr = cor_q[1];
			S_POS_C: pos_raddr = cor_q[2];
			default: ;
		endcase
	end

	always_comb begin
		acc_re    = 1'b0;
		acc_raddr = vertex_index;
		if (state_q == S_IDLE) begin
			acc_re = 1'b1;
		end else if (state_q == S_ACC_RD) begin
			acc_re    = 1'b1;
			acc_raddr = cor_q[corner_k_q];
		end
	end

	always_comb begin
		logic signed [32:0] s_ext;
		logic signed [32:0] n_ext;
		logic signed [32:0] r;
		s_ext     = '0;
		n_ext     = '0;
		r         = '0;
		acc_we    = 1'b0;
		acc_waddr = sweep_addr_q;
		acc_wdata = '0;
		if (state_q == S_SWEEP) begin
			acc_we = 1'b1;
		end else if (state_q == S_ACC_WR) begin
			acc_we    = 1'b1;
			acc_waddr = cor_q[corner_k_q];
			if (acc_rd_q.faces == 16'd0) begin
				acc_wdata.faces = 16'd1;
				for (int i = 0; i < 3; i++) acc_wdata.sum[i] = 32'(nrm_q[i]);
			end else begin
				acc_wdata.faces = (acc_rd_q.faces == 16'hFFFF) ? acc_rd_q.faces :
				                  acc_rd_q.faces + 16'd1;
				for (int i = 0; i < 3; i++) begin
					s_ext = 33'($signed(acc_rd_q.sum[i]));
					n_ext = 33'(nrm_q[i]);
					r = (dot_q > 50'sd0) ? s_ext + n_ext : s_ext - n_ext;
					if (r > 33'sd2147483647)       acc_wdata.sum[i] = 32'h7FFF_FFFF;
					else if (r < -33'sd2147483648) acc_wdata.sum[i] = 32'h8000_0000;
					else                           acc_wdata.sum[i] = r[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && operation == OP_LOAD && {1'b0, vertex_index} < lim)
			pos_mem[vertex_index] <= '{x: coord_x, y: coord_y, z: coord_z};
		pos_rd_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
		if (acc_re) acc_rd_q <= acc_mem[acc_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_addr_q <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			nx_q         <= '0;
			ny_q         <= '0;
			nz_q         <= '0;
			fc_out_q     <= '0;
			cnt_q        <= '0;
			comp_q       <= '0;
			corner_k_q   <= '0;
			mode_tri_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
					if (sweep_addr_q == ADDR_W'(MAX_VERTICES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						nx_q     <= '0;
						ny_q     <= '0;
						nz_q     <= '0;
						fc_out_q <= '0;
						cor_q[0] <= corner_a;
						cor_q[1] <= corner_b;
						cor_q[2] <= corner_c;
						unique case (operation)
							OP_LOAD: begin
								done_q <= 1'b1;
								if ({1'b0, vertex_index} >= lim) status_q <= ST_RANGE;
							end
							OP_TRI: begin
								mode_tri_q <= 1'b1;
								if (normals_present_q || vertex_count_q == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_REJECT;
								end else if ({1'b0, corner_a} >= lim ||
								             {1'b0, corner_b} >= lim ||
								             {1'b0, corner_c} >= lim) begin
									done_q   <= 1'b1;
									status_q <= ST_RANGE;
								end else begin
									state_q <= S_POS_B;
								end
							end
							OP_READ: begin
								mode_tri_q <= 1'b0;
								if ({1'b0, vertex_index} >= lim) begin
									done_q   <= 1'b1;
									status_q <= ST_RANGE;
								end else begin
									state_q <= S_RD_CHK;
								end
							end
							OP_CLEAR: begin
								done_q       <= 1'b1;
								sweep_addr_q <= '0;
								state_q      <= S_SWEEP;
							end
							default: ;
						endcase
					end
				end
				S_RD_CHK: begin
					if (acc_rd_q.faces == 16'd0) begin
						done_q   <= 1'b1;
						status_q <= ST_NOFACE;
						state_q  <= S_IDLE;
					end else begin
						fc_q <= acc_rd_q.faces;
						for (int i = 0; i < 3; i++)
							vec_q[i] <= 64'($signed(acc_rd_q.sum[i]));
						state_q <= S_CHECK;
					end
				end
				S_POS_B: begin
					pa_q    <= pos_rd_q;
					state_q <= S_POS_C;
				end
				S_POS_C: begin
					e1_q[0] <= 33'(pa_q.x) - 33'(pos_rd_q.x);
					e1_q[1] <= 33'(pa_q.y) - 33'(pos_rd_q.y);
					e1_q[2] <= 33'(pa_q.z) - 33'(pos_rd_q.z);
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					e2_q[0] <= 33'(pa_q.x) - 33'(pos_rd_q.x);
					e2_q[1] <= 33'(pa_q.y) - 33'(pos_rd_q.y);
					e2_q[2] <= 33'(pa_q.z) - 33'(pos_rd_q.z);
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					// when any edge component reaches 2^30 in magnitude, quarter all edges, rounding toward zero
					if (wide) begin
						for (int i = 0; i < 3; i++) begin
							e1_q[i] <= (e1_q[i] + (e1_q[i][32] ? 33'sd3 : 33'sd0)) >>> 2;
							e2_q[i] <= (e2_q[i] + (e2_q[i][32] ? 33'sd3 : 33'sd0)) >>> 2;
						end
					end
					cnt_q   <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					cnt_q <= cnt_q + 5'd1;
					case (cnt_q)
						5'd1, 5'd3, 5'd5: tmp_q <= mul_p_s1;
						5'd2: vec_q[0] <= tmp_q - mul_p_s1;
						5'd4: vec_q[1] <= tmp_q - mul_p_s1;
						5'd6: begin
							vec_q[2] <= tmp_q - mul_p_s1;
							state_q  <= S_CHECK;
						end
						default: ;
					endcase
				end
				S_CHECK: begin
					if (vec_q[0] == '0 && vec_q[1] == '0 && vec_q[2] == '0) begin
						done_q   <= 1'b1;
						status_q <= mode_tri_q ? ST_DEGEN : ST_OK;
						fc_out_q <= mode_tri_q ? 16'd0 : fc_q;
						state_q  <= S_IDLE;
					end else begin
						for (int i = 0; i < 3; i++) begin
							neg_q[i] <= vec_q[i][63];
							mag_q[i] <= vec_q[i][63] ? 64'(-vec_q[i]) : 64'(vec_q[i]);
						end
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					// group shift until the largest magnitude sits in [2^23, 2^24)
					if (max_mag >= 64'd1 << 28) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 4;
					end else if (max_mag >= 64'd1 << 24) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else if (max_mag < 64'd1 << 19) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 4;
					end else if (max_mag < 64'd1 << 23) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else begin
						cnt_q   <= '0;
						sq_q    <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q != 5'd0) sq_q <= sq_q + mul_p_s1[49:0];
					if (cnt_q == 5'd3) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						root_q  <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					sq_q  <= sq_q << 2;
					cnt_q <= cnt_q + 5'd1;
					if (sqrt_rem >= sqrt_trial) begin
						rem_q  <= sqrt_rem - sqrt_trial;
						root_q <= {root_q[23:0], 1'b1};
					end else begin
						rem_q  <= sqrt_rem;
						root_q <= {root_q[23:0], 1'b0};
					end
					if (cnt_q == 5'd24) begin
						comp_q  <= '0;
						state_q <= S_DIV_INIT;
					end
				end
				S_DIV_INIT: begin
					num_q   <= {mag_q[comp_q][24:0], 15'd0} + 40'(root_q);
					dsh_q   <= {root_q, 16'd0};
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_bit) num_q <= num_q - dsh_q[39:0];
					dsh_q <= dsh_q >> 1;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						nrm_q[comp_q] <= neg_q[comp_q] ? -$signed(quo_next) : $signed(quo_next);
						if (comp_q == 2'd2) begin
							state_q <= S_FIN;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= S_DIV_INIT;
						end
					end
				end
				S_FIN: begin
					if (mode_tri_q) begin
						corner_k_q <= '0;
						state_q    <= S_ACC_RD;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						nx_q     <= nrm_q[0];
						ny_q     <= nrm_q[1];
						nz_q     <= nrm_q[2];
						fc_out_q <= fc_q;
						state_q  <= S_IDLE;
					end
				end
				S_ACC_RD: begin
					cnt_q   <= '0;
					dot_q   <= '0;
					state_q <= S_DOT;
				end
				S_DOT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q != 5'd0) dot_q <= dot_q + mul_p_s1[49:0];
					if (cnt_q == 5'd3) state_q <= S_ACC_WR;
				end
				S_ACC_WR: begin
					if (corner_k_q == 2'd2) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						state_q  <= S_IDLE;
					end else begin
						corner_k_q <= corner_k_q + 2'd1;
						state_q    <= S_ACC_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MVNA_ASSERT_RST(a_reset_busy, !arst_n |-> busy, "busy low during reset")
	`MVNA_ASSERT(a_clear_sweeps, accept && operation == OP_CLEAR |=> state_q == S_SWEEP,
		"clear did not start the sweep")
	`MVNA_ASSERT(a_err_zero, done && status != ST_OK |-> nx_q == 16'sd0 && ny_q == 16'sd0 &&
		nz_q == 16'sd0 && face_count == 16'd0, "error result carries payload")
	`MVNA_ASSERT(a_norm_range, state_q == S_SQ && cnt_q == 5'd0 |->
		max_mag >= 64'd8388608 && max_mag < 64'd16777216, "magnitudes not normalised")
	`MVNA_ASSERT(a_unit_bound, done |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
		normal_y <= 16'sd16384 && normal_y >= -16'sd16384, "normal out of unit range")

endmodule
